FILE: design/stepper_command_parser_macros.svh
// Assertion macros used by the checker of the stepper command parser.
`ifndef STEPPER_COMMAND_PARSER_MACROS_SVH
`define STEPPER_COMMAND_PARSER_MACROS_SVH

// Clocked on clk, ignored while rst_n is low.
`define SCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked around reset.
`define SCP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/scp_pkg.sv
// Package: shared types and constants of the stepper command parser.
package scp_pkg;

    localparam int unsigned ARG_W = 31;

    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    localparam logic [ARG_W-1:0] ARG_MAX     = 31'h7FFF_FFFF;
    localparam logic [ARG_W-1:0] DELAY_RESET = 31'd1000;

    typedef struct packed {
        logic             move_right;
        logic [ARG_W-1:0] step_count;
        logic [ARG_W-1:0] pre_delay_ms;
    } move_t;

endpackage

FILE: design/scp_front.sv
// Front end: parses command characters and issues move descriptors.
module scp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          key_char,
    input  logic                end_of_command,
    output logic                push,
    output scp_pkg::move_t      move
);

    typedef enum logic [1:0]
    {
        CMD_NONE  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_DELAY = 2'd3
    } cmd_t;

    cmd_t                        cmd_reg;
    cmd_t                        cmd_next;
    logic [scp_pkg::ARG_W-1:0]   acc_reg;
    logic [scp_pkg::ARG_W-1:0]   acc_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic [scp_pkg::ARG_W-1:0]   delay_reg;
    logic [scp_pkg::ARG_W-1:0]   delay_next;

    logic                        is_digit;
    logic [scp_pkg::ARG_W+3:0]   prod;
    logic [scp_pkg::ARG_W-1:0]   acc_upd;
    logic                        seen_upd;
    logic                        close_now;
    logic                        emit;

    assign is_digit = (key_char >= scp_pkg::CHAR_0) && (key_char <= scp_pkg::CHAR_9);

    // acc * 10 + digit, saturated
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {31'd0, key_char[3:0]};

    always_comb
    begin
        acc_upd  = acc_reg;
        seen_upd = seen_reg;
        if (is_digit && cmd_reg != CMD_NONE)
        begin
            acc_upd  = (|prod[scp_pkg::ARG_W+3:scp_pkg::ARG_W]) ? scp_pkg::ARG_MAX
                                                                : prod[scp_pkg::ARG_W-1:0];
            seen_upd = 1'b1;
        end
    end

    assign close_now = (cmd_reg != CMD_NONE) && (!is_digit || end_of_command);
    assign emit      = close_now && seen_upd
                     && (cmd_reg == CMD_LEFT || cmd_reg == CMD_RIGHT);

    always_comb
    begin
        cmd_next   = cmd_reg;
        acc_next   = acc_upd;
        seen_next  = seen_upd;
        delay_next = delay_reg;
        if (close_now)
        begin
            if (seen_upd && cmd_reg == CMD_DELAY)
                delay_next = acc_upd;
            cmd_next  = CMD_NONE;
            acc_next  = '0;
            seen_next = 1'b0;
        end
        if (!is_digit)
        begin
            unique case (key_char)
                scp_pkg::CHAR_L: cmd_next = CMD_LEFT;
                scp_pkg::CHAR_R: cmd_next = CMD_RIGHT;
                scp_pkg::CHAR_B: cmd_next = CMD_DELAY;
                default: ;
            endcase
        end
        if (end_of_command)
        begin
            cmd_next  = CMD_NONE;
            acc_next  = '0;
            seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_NONE;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            delay_reg <= scp_pkg::DELAY_RESET;
        end
        else if (accept)
        begin
            cmd_reg   <= cmd_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            delay_reg <= delay_next;
        end
    end

    assign push              = accept && emit;
    assign move.move_right   = (cmd_reg == CMD_RIGHT);
    assign move.step_count   = acc_upd;
    assign move.pre_delay_ms = delay_reg;

endmodule

FILE: design/scp_queue.sv
// Move queue between the parser front end and the output stage.
module scp_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scp_pkg::move_t  push_data,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output scp_pkg::move_t  head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    scp_pkg::move_t  mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/scp_back.sv
// Back end: output register that presents one move per transfer.
module scp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  scp_pkg::move_t  q_head,
    output logic            pop,
    input  logic            out_stall,
    output logic            out_valid,
    output scp_pkg::move_t  out_move
);

    logic            valid_reg;
    scp_pkg::move_t  move_reg;

    assign pop = q_valid && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            move_reg <= q_head;
    end

    assign out_valid = valid_reg;
    assign out_move  = move_reg;

endmodule

FILE: design/stepper_command_parser.sv
// Top level of the stepper command parser.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+---------------------------------------
//  input   | in        | in_valid / in_stall | key_char, end_of_command
//  output  | out       | out_valid/out_stall | move_right, step_count, pre_delay_ms
//
// One character is taken per cycle while in_stall is low; the parser state updates on each taken character.
// A closed move passes through the move queue and then the output register before it appears at the outputs.
// in_stall rises only when the move queue (QUEUE_DEPTH entries) is full.
// Reset clears the open command and sets the delay to 1000 ms.
module stepper_command_parser
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  key_char,
    input  logic        end_of_command,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        move_right,
    output logic [30:0] step_count,
    output logic [30:0] pre_delay_ms
);

    logic            accept;
    logic            push;
    scp_pkg::move_t  front_move;
    logic            q_full;
    logic            q_valid;
    scp_pkg::move_t  q_head;
    logic            pop;
    scp_pkg::move_t  out_move;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    scp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .key_char       (key_char),
        .end_of_command (end_of_command),
        .push           (push),
        .move           (front_move)
    );

    scp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_move),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    scp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_move  (out_move)
    );

    assign move_right   = out_move.move_right;
    assign step_count   = out_move.step_count;
    assign pre_delay_ms = out_move.pre_delay_ms;

endmodule

FILE: design/scp_checker.sv
// Port-level checker for the stepper command parser, bound to the top level.
`include "stepper_command_parser_macros.svh"

module scp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  key_char,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        move_right,
    input  logic [30:0] step_count,
    input  logic [30:0] pre_delay_ms
);

    logic digit_seen_reg;
    logic delay_cmd_seen_reg;
    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_seen_reg     <= 1'b0;
            delay_cmd_seen_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (key_char >= scp_pkg::CHAR_0 && key_char <= scp_pkg::CHAR_9)
                digit_seen_reg <= 1'b1;
            if (key_char == scp_pkg::CHAR_B)
                delay_cmd_seen_reg <= 1'b1;
        end
    end

    `SCP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid,
                "output transfer dropped while stalled")
    `SCP_ASSERT(a_out_stable,
                out_valid && out_stall |=> $stable(move_right) && $stable(step_count)
                    && $stable(pre_delay_ms),
                "output payload changed while stalled")
    `SCP_ASSERT_RST(a_reset_empty, $rose(rst_n) |-> !out_valid,
                    "output valid right after reset")
    `SCP_ASSERT(a_move_needs_digit, out_valid |-> digit_seen_reg,
                "move without any digit")
    `SCP_ASSERT(a_default_delay,
                out_valid && !delay_cmd_seen_reg |-> pre_delay_ms == scp_pkg::DELAY_RESET,
                "delay changed without a delay command")

endmodule

bind stepper_command_parser scp_checker u_scp_checker (.*);

FILE: tb/sv/stepper_command_parser_test.sv
// Self-checking testbench for the stepper command parser: directed strings plus random commands.
module stepper_command_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CHARS = 1900;

    typedef enum logic [1:0] {CMD_NONE, CMD_LEFT, CMD_RIGHT, CMD_DELAY} command_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_t;
    typedef logic [7:0] char_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  key_char = 8'h00;
    logic        end_of_command = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        move_right;
    logic [30:0] step_count;
    logic [30:0] pre_delay_ms;

    // parser model state
    command_t                  open_cmd = CMD_NONE;
    logic [scp_pkg::ARG_W-1:0] arg_acc = '0;
    logic                      arg_seen = 1'b0;
    logic [scp_pkg::ARG_W-1:0] delay_ms = scp_pkg::DELAY_RESET;
    scp_pkg::move_t            expected_moves[$];

    int             errors = 0;
    int             chars_accepted = 0;
    int             moves_checked = 0;
    int             delay_updates = 0;
    int             saturated_digits = 0;
    int             burst_left = 0;
    int             cycle_count = 0;
    stall_t         stall_mode = STALL_NONE;
    int             stall_left = 0;
    scp_pkg::move_t want_move;

    stepper_command_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_char       (key_char),
        .end_of_command (end_of_command),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .move_right     (move_right),
        .step_count     (step_count),
        .pre_delay_ms   (pre_delay_ms)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void close_command();
        scp_pkg::move_t m;
        if (arg_seen)
        begin
            if (open_cmd == CMD_LEFT || open_cmd == CMD_RIGHT)
            begin
                m.move_right   = (open_cmd == CMD_RIGHT);
                m.step_count   = arg_acc;
                m.pre_delay_ms = delay_ms;
                expected_moves.push_back(m);
            end
            else if (open_cmd == CMD_DELAY)
            begin
                delay_ms = arg_acc;
                delay_updates++;
            end
        end
        open_cmd = CMD_NONE;
        arg_acc  = '0;
        arg_seen = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] key, input logic last);
        logic [34:0] next_arg;
        if (key >= scp_pkg::CHAR_0 && key <= scp_pkg::CHAR_9)
        begin
            if (open_cmd != CMD_NONE)
            begin
                next_arg = 35'(arg_acc) * 35'd10 + 35'(key - scp_pkg::CHAR_0);
                if (next_arg > 35'(scp_pkg::ARG_MAX))
                begin
                    next_arg = 35'(scp_pkg::ARG_MAX);
                    saturated_digits++;
                end
                arg_acc  = next_arg[scp_pkg::ARG_W-1:0];
                arg_seen = 1'b1;
            end
        end
        else
        begin
            if (open_cmd != CMD_NONE)
                close_command();
            case (key)
                scp_pkg::CHAR_L: open_cmd = CMD_LEFT;
                scp_pkg::CHAR_R: open_cmd = CMD_RIGHT;
                scp_pkg::CHAR_B: open_cmd = CMD_DELAY;
                default: ;
            endcase
        end
        if (last)
            close_command();
    endfunction

    task automatic compare_field(input string name, input logic [30:0] want,
                                 input logic [30:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // input monitor, move checker and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_char(key_char, end_of_command);
                chars_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_moves.size() == 0)
                begin
                    $display("%0t: unexpected move, expected none, got right=%0d steps=%0d delay=%0d",
                             $time, move_right, step_count, pre_delay_ms);
                    errors++;
                end
                else
                begin
                    want_move = expected_moves.pop_front();
                    compare_field("move_right", 31'(want_move.move_right), 31'(move_right));
                    compare_field("step_count", want_move.step_count, step_count);
                    compare_field("pre_delay_ms", want_move.pre_delay_ms, pre_delay_ms);
                    moves_checked++;
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = stall_t'($urandom_range(3));
            stall_left = $urandom_range(300, 30);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
            default:     out_stall <= stall_left[2];
        endcase
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stepper_command_parser: mismatch");
        $finish;
    end

    task automatic send_char(input logic [7:0] key, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(4) == 0)
            begin
                burst_left = 200;
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(40, 1);
                gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        key_char       <= key;
        end_of_command <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1);
    endtask

    task automatic send_chars(input char_q_t text, input int split_at);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], (i == text.size() - 1) || (i == split_at));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_moves.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_zero_and_letter_close();
        send_text("L0");
        send_text("B0R5");
        pause_until_drained();
    endtask

    task automatic test_ignored_input();
        send_text("9");
        send_char(scp_pkg::CHAR_L, 1'b0);
        send_char("+", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(scp_pkg::CHAR_R, 1'b0);
        send_char(" ", 1'b0);
        send_char(8'hFF, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_saturation();
        send_text("R9999999999");
        pause_until_drained();
    endtask

    task automatic test_random_commands(input int target);
        char_q_t    text;
        int         live;
        int         next_pause;
        int         n_digits;
        int         pick;
        int         split_at;
        logic [7:0] sep;
        live = 0;
        next_pause = 400;
        while (live < target)
        begin
            text.delete();
            repeat ($urandom_range(6, 1))
            begin
                case ($urandom_range(19))
                    0: text.push_back(8'($urandom_range(255)));
                    1: text.push_back(scp_pkg::CHAR_0 + 8'($urandom_range(9)));
                    default:
                    begin
                        pick = $urandom_range(4);
                        text.push_back(pick < 2 ? scp_pkg::CHAR_L
                                                : (pick < 4 ? scp_pkg::CHAR_R : scp_pkg::CHAR_B));
                        live++;
                        pick = $urandom_range(19);
                        if (pick == 0)
                            n_digits = 0;
                        else if (pick < 3)
                            n_digits = $urandom_range(13, 10);
                        else if (pick < 6)
                            n_digits = $urandom_range(9, 5);
                        else
                            n_digits = $urandom_range(4, 1);
                        repeat (n_digits)
                        begin
                            text.push_back(scp_pkg::CHAR_0 + 8'($urandom_range(9)));
                            live++;
                        end
                        if ($urandom_range(3) == 0)
                        begin
                            case ($urandom_range(3))
                                0: sep = " ";
                                1: sep = "-";
                                2: sep = "+";
                                default: sep = 8'($urandom_range(255));
                            endcase
                            text.push_back(sep);
                            live++;
                        end
                    end
                endcase
            end
            split_at = ($urandom_range(9) == 0) ? $urandom_range(text.size() - 1) : -1;
            send_chars(text, split_at);
            if (live >= next_pause)
            begin
                pause_until_drained();
                next_pause += 400;
            end
        end
        pause_until_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_and_letter_close();
        test_ignored_input();
        test_saturation();
        test_random_commands(RANDOM_CHARS);
        $display("Sent %0d characters; checked %0d moves, %0d delay changes.",
                 chars_accepted, moves_checked, delay_updates);
        $display("Digits that hit the argument limit: %0d; delay at end %0d ms.",
                 saturated_digits, delay_ms);
        if (errors == 0)
            $display("stepper_command_parser: match");
        else
            $display("stepper_command_parser: mismatch");
        $finish;
    end

endmodule

FILE: stepper_command_parser.f
+incdir+design
design/scp_pkg.sv
design/scp_front.sv
design/scp_queue.sv
design/scp_back.sv
design/stepper_command_parser.sv
design/scp_checker.sv
tb/sv/stepper_command_parser_test.sv
